@@ rtl/chm_pkg.sv @@
// Package for the chained hash multiset: action and status codes and the
// result type shared by the top level and its port checker.
// No dependencies.
`default_nettype none

package chm_pkg;

   // result code of one beat on the response channel
   typedef logic [1:0] status_type;

   localparam logic       ACT_INSERT  = 1'b0;
   localparam logic       ACT_REMOVE  = 1'b1;

   localparam status_type ST_INSERTED = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_REMOVED  = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

@@ rtl/chained_hash_multiset.sv @@
// From an accepted beat to rsp_valid: S_START, S_HEAD, one S_WALK per chain node visited
// and S_PUT (a full pool goes from S_START to S_PUT), with S_ALLOC when an insert reuses a
// freed node and S_LINK for an unlink; a BUCKETS not a power of two adds S_MOD and S_MODR
// per 16 bits of value. One item at a time: S_PUT waits while an earlier result is stalled,
// and req_ready rises as the result is loaded into rsp_status. Reset is synchronous; then
// S_CLEAR sets every bucket head to NIL, with req_ready low throughout. Depends on chm_pkg.
`default_nettype none

module chained_hash_multiset #(
   parameter int BUCKETS    = 1024,
   parameter int POOL_NODES = 1024,
   parameter int VALUE_BITS = 31
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_action,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      chm_pkg::status_type   rsp_status
);

   localparam int  NODE_W    = $clog2(POOL_NODES + 1);
   localparam int  IDX_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int  BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int  DIG_W     = 16;
   localparam int  NDIG      = (VALUE_BITS + DIG_W - 1) / DIG_W;
   localparam int  DIG_IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int  T_W       = BKT_W + DIG_W;
   localparam bit  BKT_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam logic [NODE_W-1:0] NIL       = NODE_W'(POOL_NODES);
   localparam logic [BKT_W:0]    BKT_NUM   = (BKT_W + 1)'(BUCKETS);
   localparam logic [32:0]       MOD_RECIP = 33'(64'h1_0000_0000 / 64'(BUCKETS));

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_MOD   = 10'b0000000100,
      S_MODR  = 10'b0000001000,
      S_START = 10'b0000010000,
      S_ALLOC = 10'b0000100000,
      S_HEAD  = 10'b0001000000,
      S_WALK  = 10'b0010000000,
      S_LINK  = 10'b0100000000,
      S_PUT   = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [BKT_W-1:0]     bkt_ff, bkt_in;
   logic [BKT_W-1:0]     clr_ff, clr_in;
   logic [DIG_IDX_W-1:0] dig_ff, dig_in;
   logic [T_W-1:0]       modt_ff, modt_in;
   logic [DIG_W-1:0]     quot_ff, quot_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                 act_ff, act_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    prev_ff, prev_in;
   logic [NODE_W-1:0]    new_ff, new_in;
   logic [NODE_W-1:0]    free_ff, free_in;
   logic [NODE_W-1:0]    fresh_ff, fresh_in;
   chm_pkg::status_type  stat_ff, stat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   chm_pkg::status_type  rsp_status_ff, rsp_status_in;

   // memory ports
   logic [NODE_W-1:0]     head_mem [BUCKETS];
   logic [NODE_W-1:0]     next_mem [POOL_NODES];
   logic [VALUE_BITS-1:0] value_mem [POOL_NODES];
   logic [NODE_W-1:0]     head_rd_ff;
   logic [NODE_W-1:0]     next_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;
   logic                  head_we;
   logic [BKT_W-1:0]      head_waddr;
   logic [NODE_W-1:0]     head_wdata;
   logic                  next_we;
   logic                  value_we;
   logic [IDX_W-1:0]      node_waddr;
   logic [NODE_W-1:0]     next_wdata;
   logic [IDX_W-1:0]      node_raddr;

   // bucket reduction datapath
   logic [NDIG*DIG_W-1:0] val_pad;
   logic [T_W-1:0]        mod_t;
   logic [T_W+32:0]       mod_prod;
   logic [T_W-1:0]        mod_qb;
   logic [T_W-1:0]        mod_rest;
   logic [BKT_W:0]        mod_r;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // one 16-bit digit of value mod BUCKETS, most significant digit first:
   // estimate the quotient by reciprocal, then subtract and correct once
   assign val_pad  = (NDIG * DIG_W)'(val_ff);
   assign mod_t    = {bkt_ff, val_pad[int'(dig_ff) * DIG_W +: DIG_W]};
   assign mod_prod = (T_W + 33)'(mod_t) * (T_W + 33)'(MOD_RECIP);
   assign mod_qb   = T_W'(quot_ff) * T_W'(BKT_NUM);
   assign mod_rest = modt_ff - mod_qb;
   assign mod_r    = mod_rest[BKT_W:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      bkt_in        = bkt_ff;
      clr_in        = clr_ff;
      dig_in        = dig_ff;
      modt_in       = modt_ff;
      quot_in       = quot_ff;
      val_in        = val_ff;
      act_in        = act_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      new_in        = new_ff;
      free_in       = free_ff;
      fresh_in      = fresh_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      head_we       = 1'b0;
      head_waddr    = bkt_ff;
      head_wdata    = new_ff;
      next_we       = 1'b0;
      value_we      = 1'b0;
      node_waddr    = new_ff[IDX_W-1:0];
      next_wdata    = NIL;
      node_raddr    = cur_ff[IDX_W-1:0];

      // drop the result once its beat is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_ff;
            head_wdata = NIL;
            clr_in     = clr_ff + BKT_W'(1);
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_value;
               act_in = req_action;
               if (BKT_POW2) begin
                  bkt_in   = BKT_W'(req_value) & BKT_W'(BUCKETS - 1);
                  state_in = S_START;
               end else begin
                  bkt_in   = '0;
                  dig_in   = DIG_IDX_W'(NDIG - 1);
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // register the partial dividend and its quotient estimate
            modt_in  = mod_t;
            quot_in  = mod_prod[32 +: DIG_W];
            state_in = S_MODR;
         end
         S_MODR: begin
            if (mod_r >= BKT_NUM) begin
               bkt_in = BKT_W'(mod_r - BKT_NUM);
            end else begin
               bkt_in = mod_r[BKT_W-1:0];
            end
            dig_in = dig_ff - DIG_IDX_W'(1);
            if (dig_ff == '0) begin
               state_in = S_START;
            end else begin
               state_in = S_MOD;
            end
         end
         S_START: begin
            // bucket head is being read; pick a node for an insert
            if (act_ff == chm_pkg::ACT_REMOVE) begin
               state_in = S_HEAD;
            end else if (free_ff != NIL) begin
               node_raddr = free_ff[IDX_W-1:0];
               state_in   = S_ALLOC;
            end else if (fresh_ff != NIL) begin
               new_in     = fresh_ff;
               fresh_in   = fresh_ff + NODE_W'(1);
               node_waddr = fresh_ff[IDX_W-1:0];
               next_we    = 1'b1;
               value_we   = 1'b1;
               state_in   = S_HEAD;
            end else begin
               stat_in  = chm_pkg::ST_FULL;
               state_in = S_PUT;
            end
         end
         S_ALLOC: begin
            // pop the free list
            new_in     = free_ff;
            free_in    = next_rd_ff;
            node_waddr = free_ff[IDX_W-1:0];
            next_we    = 1'b1;
            value_we   = 1'b1;
            state_in   = S_HEAD;
         end
         S_HEAD: begin
            if (head_rd_ff == NIL) begin
               if (act_ff == chm_pkg::ACT_INSERT) begin
                  head_we = 1'b1;
                  stat_in = chm_pkg::ST_INSERTED;
               end else begin
                  stat_in = chm_pkg::ST_NOTFOUND;
               end
               state_in = S_PUT;
            end else begin
               cur_in     = head_rd_ff;
               prev_in    = NIL;
               node_raddr = head_rd_ff[IDX_W-1:0];
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (act_ff == chm_pkg::ACT_REMOVE && value_rd_ff == val_ff) begin
               // unlink the match from its predecessor
               if (prev_ff == NIL) begin
                  head_we    = 1'b1;
                  head_wdata = next_rd_ff;
               end else begin
                  next_we    = 1'b1;
                  node_waddr = prev_ff[IDX_W-1:0];
                  next_wdata = next_rd_ff;
               end
               state_in = S_LINK;
            end else if (next_rd_ff == NIL) begin
               if (act_ff == chm_pkg::ACT_INSERT) begin
                  next_we    = 1'b1;
                  node_waddr = cur_ff[IDX_W-1:0];
                  next_wdata = new_ff;
                  stat_in    = chm_pkg::ST_INSERTED;
               end else begin
                  stat_in    = chm_pkg::ST_NOTFOUND;
               end
               state_in = S_PUT;
            end else begin
               prev_in    = cur_ff;
               cur_in     = next_rd_ff;
               node_raddr = next_rd_ff[IDX_W-1:0];
            end
         end
         S_LINK: begin
            // push the removed node onto the free list
            next_we    = 1'b1;
            node_waddr = cur_ff[IDX_W-1:0];
            next_wdata = free_ff;
            free_in    = cur_ff;
            stat_in    = chm_pkg::ST_REMOVED;
            state_in   = S_PUT;
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= NIL;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bkt_ff        <= bkt_in;
      dig_ff        <= dig_in;
      modt_ff       <= modt_in;
      quot_ff       <= quot_in;
      val_ff        <= val_in;
      act_ff        <= act_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      new_ff        <= new_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
   end

   // bucket head memory, read at the current bucket every cycle
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rd_ff <= head_mem[bkt_ff];
   end

   // node link and value memories, shared addresses
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[node_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[node_waddr] <= val_ff;
      end
      value_rd_ff <= value_mem[node_raddr];
   end

endmodule

`default_nettype wire

@@ rtl/chm_checker.sv @@
// Port checker for chained_hash_multiset and the bind that attaches it.
// Watches the request and response handshakes only. Depends on chm_pkg.
`default_nettype none

module chm_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire chm_pkg::status_type rsp_status
);

   logic [1:0] pend_ff, pend_in;

   // count items accepted whose result beat is not yet taken
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // clearing pass follows reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("ports active straight after reset");

   // no result without an item
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result beat without an accepted item");

   // at most one item in work beside a waiting result
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> pend_ff == 2'd0 || pend_ff == 2'd1)
      else $error("item accepted while two are outstanding");

endmodule

bind chained_hash_multiset chm_checker u_chm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status)
);

`default_nettype wire
